>>> design/smcp_pkg.sv
// Shared types and constants for the sprite movie command parser.
package smcp_pkg;

  localparam logic [3:0] MODE_IDLE   = 4'd0;
  localparam logic [3:0] MODE_CMD    = 4'd1;
  localparam logic [3:0] MODE_FIELDS = 4'd2;
  localparam logic [3:0] MODE_PIXELS = 4'd3;
  localparam logic [3:0] MODE_WAIT   = 4'd4;
  localparam logic [3:0] MODE_SKIP   = 4'd5;

  localparam logic [2:0] KIND_WINDOW   = 3'd0;
  localparam logic [2:0] KIND_PIXEL    = 3'd1;
  localparam logic [2:0] KIND_FILL     = 3'd2;
  localparam logic [2:0] KIND_SEEK     = 3'd3;
  localparam logic [2:0] KIND_WAITDONE = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;
  localparam logic [2:0] KIND_ABORT    = 3'd6;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_KEY   = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;

  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_WB = 8'h57;
  localparam logic [7:0] CH_WS = 8'h77;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_SB = 8'h53;
  localparam logic [7:0] CH_SS = 8'h73;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;

  // one result item
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [10:0] coord_a;
    logic signed [10:0] coord_b;
    logic signed [10:0] coord_c;
    logic signed [10:0] coord_d;
    logic [15:0]        payload;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       block_start;
  } req_t;

  function automatic logic [2:0] fields_needed(input logic [7:0] c);
    case (c)
      CH_P:  fields_needed = 3'd4;
      CH_F:  fields_needed = 3'd6;
      CH_WB: fields_needed = 3'd1;
      CH_WS: fields_needed = 3'd2;
      CH_SB: fields_needed = 3'd1;
      CH_SS: fields_needed = 3'd2;
      CH_A:  fields_needed = 3'd2;
      default: fields_needed = 3'd0;
    endcase
  endfunction

endpackage

>>> design/sprite_movie_command_parser_top.sv
// Top level of the sprite movie command parser.
//
// Channels: input queue (in_push / in_full) takes one request per cycle while in_full is low:
//   file byte, millisecond tick, key event or start. Result queue
//   (out_empty / out_pop) presents the oldest result on the out_ ports.
// cfg_valid / cfg_ready writes screen width (0), height (1) and the key
//   ignore mask (2); cfg_ready is always high.
// Front: a two-entry request queue. Back: the command state machine, which
//   takes one request per cycle while the two-entry result queue has room.
// Path: a request is registered in the request queue, handled combinationally
//   by the back end, and its result is registered in the result queue, whose
//   oldest entry is on the out_ ports.
// Throughput: one request per cycle while the result queue has room.
// Reset: parser goes idle (waits for a start request), origin and timer
//   clear, registers return to 160 / 128 / 1.
// Receiver stall: the result queue fills, the back end stops taking
//   requests, the request queue fills and in_full rises. Nothing is lost.
module sprite_movie_command_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic signed [10:0] out_coord_a,
  output logic signed [10:0] out_coord_b,
  output logic signed [10:0] out_coord_c,
  output logic signed [10:0] out_coord_d,
  output logic [15:0] out_payload,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  logic [9:0] scr_w_r, scr_h_r;
  logic [7:0] mask_r;
  smcp_pkg::req_t req_in, req_q;
  smcp_pkg::res_t res_d, res_q;
  logic req_empty, req_take, res_valid, res_full;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 10'd160; scr_h_r <= 10'd128; mask_r <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        smcp_pkg::CFG_WIDTH:  scr_w_r <= cfg_data;
        smcp_pkg::CFG_HEIGHT: scr_h_r <= cfg_data;
        smcp_pkg::CFG_MASK:   mask_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign req_in = '{req_type: in_req_type, data_byte: in_data_byte,
                    block_start: in_block_start};

  smcp_fifo #(.W($bits(smcp_pkg::req_t))) u_req_q (
    .clk, .rst_n, .wr_en(in_push), .wr_data(req_in), .full(in_full),
    .rd_en(req_take), .rd_data(req_q), .empty(req_empty));

  smcp_exec u_exec (
    .clk, .rst_n, .req_valid(!req_empty), .req(req_q), .req_take,
    .scr_w(scr_w_r), .scr_h(scr_h_r), .key_mask(mask_r),
    .res_valid, .res(res_d), .res_full);

  smcp_fifo #(.W($bits(smcp_pkg::res_t))) u_res_q (
    .clk, .rst_n, .wr_en(res_valid), .wr_data(res_d), .full(res_full),
    .rd_en(out_pop), .rd_data(res_q), .empty(out_empty));

  assign out_kind    = res_q.kind;
  assign out_coord_a = res_q.coord_a;
  assign out_coord_b = res_q.coord_b;
  assign out_coord_c = res_q.coord_c;
  assign out_coord_d = res_q.coord_d;
  assign out_payload = res_q.payload;

  // a result is only produced for a request actually taken
  a_res_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> req_take) else $error("result without request");
  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_full |-> !req_take) else $error("request taken while result queue full");
  // kind stays in the defined range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_kind != 3'd7) else $error("undefined result kind");
endmodule

>>> design/smcp_fifo.sv
// Small two-entry request/result queue.
module smcp_fifo #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en && !full) wp_r <= ~wp_r;
      if (rd_en && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
    end
  end
endmodule

>>> design/smcp_exec.sv
// Back end: command state machine that turns requests into results.
module smcp_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  smcp_pkg::req_t   req,
  output logic             req_take,
  input  logic [9:0]       scr_w,
  input  logic [9:0]       scr_h,
  input  logic [7:0]       key_mask,
  output logic             res_valid,
  output smcp_pkg::res_t   res,
  input  logic             res_full
);
  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [7:0]  fs_r [5];
  logic [16:0] left_r, left_nxt;
  logic signed [10:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [15:0] el_r, el_nxt, tgt_r, tgt_nxt;
  logic [7:0]  v;
  logic        wr_fs;
  logic [15:0] tnew;
  logic signed [10:0] sx, sy, dx, dy;

  // only take a request when a result slot is free
  assign req_take = req_valid && !res_full;
  assign v = req.data_byte;
  assign sx = $signed({1'b0, scr_w}) - $signed({3'b000, fs_r[0]});
  assign sy = $signed({1'b0, scr_h}) - $signed({3'b000, v});

  always_comb begin
    mode_nxt = mode_r; cmd_nxt = cmd_r; fidx_nxt = fidx_r; left_nxt = left_r;
    ox_nxt = ox_r; oy_nxt = oy_r; el_nxt = el_r; tgt_nxt = tgt_r;
    wr_fs = 1'b0; res_valid = 1'b0; res = '0; tnew = '0;
    dx = '0; dy = '0;
    if (req_take) begin
      if (req.req_type == smcp_pkg::REQ_START) begin
        mode_nxt = smcp_pkg::MODE_CMD; cmd_nxt = '0; fidx_nxt = '0; left_nxt = '0;
        ox_nxt = '0; oy_nxt = '0; el_nxt = '0; tgt_nxt = '0;
      end else if (mode_r == smcp_pkg::MODE_IDLE) begin
        mode_nxt = mode_r;
      end else if (req.req_type == smcp_pkg::REQ_TICK) begin
        if (el_r != 16'hFFFF) el_nxt = el_r + 16'd1;
        if (mode_r == smcp_pkg::MODE_WAIT && el_nxt >= tgt_r) begin
          el_nxt = '0; mode_nxt = smcp_pkg::MODE_CMD;
          res_valid = 1'b1; res.kind = smcp_pkg::KIND_WAITDONE;
        end
      end else if (req.req_type == smcp_pkg::REQ_KEY) begin
        if (mode_r == smcp_pkg::MODE_WAIT && (v & ~key_mask) != 8'd0) begin
          mode_nxt = smcp_pkg::MODE_IDLE;
          res_valid = 1'b1; res.kind = smcp_pkg::KIND_ABORT; res.payload = {8'd0, v};
        end
      end else begin
        case (mode_r)
          smcp_pkg::MODE_CMD, smcp_pkg::MODE_SKIP: begin
            if (mode_r == smcp_pkg::MODE_CMD || req.block_start) begin
              mode_nxt = smcp_pkg::MODE_CMD;
              if (v == smcp_pkg::CH_N) mode_nxt = smcp_pkg::MODE_SKIP;
              else if (v == smcp_pkg::CH_Z) begin
                mode_nxt = smcp_pkg::MODE_IDLE;
                res_valid = 1'b1; res.kind = smcp_pkg::KIND_END;
              end else if (smcp_pkg::fields_needed(v) != 3'd0) begin
                cmd_nxt = v; fidx_nxt = '0; mode_nxt = smcp_pkg::MODE_FIELDS;
              end
            end
          end
          smcp_pkg::MODE_FIELDS: begin
            wr_fs = 1'b1;
            fidx_nxt = fidx_r + 3'd1;
            if (fidx_nxt >= smcp_pkg::fields_needed(cmd_r)) begin
              mode_nxt = smcp_pkg::MODE_CMD;
              case (cmd_r)
                smcp_pkg::CH_P: begin
                  // last field is h = v
                  left_nxt = {(16'(fs_r[2]) * 16'(v)), 1'b0};
                  if (left_nxt != 17'd0) begin
                    mode_nxt = smcp_pkg::MODE_PIXELS;
                    res_valid = 1'b1; res.kind = smcp_pkg::KIND_WINDOW;
                    res.coord_a = ox_r + $signed({3'b000, fs_r[0]});
                    res.coord_b = oy_r + $signed({3'b000, fs_r[1]});
                    res.coord_c = res.coord_a + $signed({3'b000, fs_r[2]}) - 11'sd1;
                    res.coord_d = res.coord_b + $signed({3'b000, v}) - 11'sd1;
                  end
                end
                smcp_pkg::CH_F: begin
                  res_valid = 1'b1; res.kind = smcp_pkg::KIND_FILL;
                  res.coord_a = ox_r + $signed({3'b000, fs_r[0]});
                  res.coord_b = oy_r + $signed({3'b000, fs_r[1]});
                  res.coord_c = $signed({3'b000, fs_r[2]});
                  res.coord_d = $signed({3'b000, fs_r[3]});
                  res.payload = {fs_r[4], v};
                end
                smcp_pkg::CH_WB, smcp_pkg::CH_WS: begin
                  tnew = (cmd_r == smcp_pkg::CH_WB) ? {8'd0, v} : {fs_r[0], v};
                  tgt_nxt = tnew; mode_nxt = smcp_pkg::MODE_WAIT;
                  if (el_r >= tnew) begin
                    el_nxt = '0; mode_nxt = smcp_pkg::MODE_CMD;
                    res_valid = 1'b1; res.kind = smcp_pkg::KIND_WAITDONE;
                  end
                end
                smcp_pkg::CH_SB, smcp_pkg::CH_SS: begin
                  mode_nxt = smcp_pkg::MODE_SKIP;
                  res_valid = 1'b1; res.kind = smcp_pkg::KIND_SEEK;
                  res.payload = (cmd_r == smcp_pkg::CH_SB) ? {8'd0, v} : {fs_r[0], v};
                end
                smcp_pkg::CH_A: begin
                  // floor halving of screen minus content size
                  dx = sx >>> 1; dy = sy >>> 1;
                  ox_nxt = dx; oy_nxt = dy;
                end
                default: mode_nxt = smcp_pkg::MODE_CMD;
              endcase
            end
          end
          smcp_pkg::MODE_PIXELS: begin
            left_nxt = left_r - 17'd1;
            if (left_nxt == 17'd0) mode_nxt = smcp_pkg::MODE_CMD;
            res_valid = 1'b1; res.kind = smcp_pkg::KIND_PIXEL; res.payload = {8'd0, v};
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '{default: 8'd0};
    end else if (req_take && req.req_type == smcp_pkg::REQ_BYTE && wr_fs && fidx_r < 3'd5) begin
      fs_r[fidx_r] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= smcp_pkg::MODE_IDLE; cmd_r <= '0; fidx_r <= '0; left_r <= '0;
      ox_r <= '0; oy_r <= '0; el_r <= '0; tgt_r <= '0;
    end else begin
      mode_r <= mode_nxt; cmd_r <= cmd_nxt; fidx_r <= fidx_nxt; left_r <= left_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt; el_r <= el_nxt; tgt_r <= tgt_nxt;
    end
  end
endmodule

>>> tb/sv/sprite_movie_command_parser_checker.sv
// Checker for the sprite movie command parser: predicts results and compares them.
`timescale 1ns / 1ps

module sprite_movie_command_parser_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_data_byte,
  input  logic               in_block_start,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [2:0]         out_kind,
  input  logic signed [10:0] out_coord_a,
  input  logic signed [10:0] out_coord_b,
  input  logic signed [10:0] out_coord_c,
  input  logic signed [10:0] out_coord_d,
  input  logic [15:0]        out_payload,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  smcp_pkg::res_t expected_results[$];

  // predictor state
  logic [9:0]  scr_w, scr_h;
  logic [7:0]  ign_mask;
  logic [3:0]  mode;
  logic [7:0]  cmd;
  logic [2:0]  fidx;
  logic [7:0]  fst[5];
  int          pix_left;
  int          org_x, org_y;
  int          elapsed;
  int          target;

  function automatic int field_count(input logic [7:0] c);
    case (c)
      smcp_pkg::CH_P: return 4;
      smcp_pkg::CH_F: return 6;
      smcp_pkg::CH_WB, smcp_pkg::CH_SB: return 1;
      smcp_pkg::CH_WS, smcp_pkg::CH_SS, smcp_pkg::CH_A: return 2;
      default: return -1;
    endcase
  endfunction

  function automatic smcp_pkg::res_t mk(input logic [2:0] k, input int a, input int b,
                                        input int c, input int d, input int p);
    smcp_pkg::res_t r;
    r.kind = k;
    r.coord_a = a[10:0];
    r.coord_b = b[10:0];
    r.coord_c = c[10:0];
    r.coord_d = d[10:0];
    r.payload = p[15:0];
    return r;
  endfunction

  function automatic bit wait_over(output smcp_pkg::res_t r);
    r = '0;
    if (elapsed >= target) begin
      elapsed = 0;
      mode = smcp_pkg::MODE_CMD;
      r = mk(smcp_pkg::KIND_WAITDONE, 0, 0, 0, 0, 0);
      return 1;
    end
    return 0;
  endfunction

  function automatic bit command_start(input logic [7:0] c, output smcp_pkg::res_t r);
    r = '0;
    if (c == smcp_pkg::CH_N) begin
      mode = smcp_pkg::MODE_SKIP;
      return 0;
    end
    if (c == smcp_pkg::CH_Z) begin
      mode = smcp_pkg::MODE_IDLE;
      r = mk(smcp_pkg::KIND_END, 0, 0, 0, 0, 0);
      return 1;
    end
    if (field_count(c) > 0) begin
      cmd = c;
      fidx = '0;
      mode = smcp_pkg::MODE_FIELDS;
    end
    return 0;
  endfunction

  function automatic bit field_in(input logic [7:0] v, output smcp_pkg::res_t r);
    int x, y, w, h, dx, dy;
    r = '0;
    if (fidx < 3'd5) fst[fidx] = v;
    fidx = fidx + 3'd1;
    if (int'(fidx) < field_count(cmd)) return 0;
    mode = smcp_pkg::MODE_CMD;
    x = int'(fst[0]);
    y = int'(fst[1]);
    w = int'(fst[2]);
    h = int'(fst[3]);
    case (cmd)
      smcp_pkg::CH_P: begin
        pix_left = w * h * 2;
        if (pix_left == 0) return 0;
        mode = smcp_pkg::MODE_PIXELS;
        r = mk(smcp_pkg::KIND_WINDOW, org_x + x, org_y + y, org_x + x + w - 1,
               org_y + y + h - 1, 0);
        return 1;
      end
      smcp_pkg::CH_F: begin
        r = mk(smcp_pkg::KIND_FILL, org_x + x, org_y + y, w, h, int'({fst[4], v}));
        return 1;
      end
      smcp_pkg::CH_WB, smcp_pkg::CH_WS: begin
        target = (cmd == smcp_pkg::CH_WB) ? int'(fst[0]) : int'({fst[0], fst[1]});
        mode = smcp_pkg::MODE_WAIT;
        return wait_over(r);
      end
      smcp_pkg::CH_SB, smcp_pkg::CH_SS: begin
        mode = smcp_pkg::MODE_SKIP;
        r = mk(smcp_pkg::KIND_SEEK, 0, 0, 0, 0,
               (cmd == smcp_pkg::CH_SB) ? int'(fst[0]) : int'({fst[0], fst[1]}));
        return 1;
      end
      smcp_pkg::CH_A: begin
        // floor of half the difference, per axis
        dx = int'(scr_w) - int'(fst[0]);
        dy = int'(scr_h) - int'(fst[1]);
        org_x = dx >>> 1;
        org_y = dy >>> 1;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit parse_request(input logic [1:0] t, input logic [7:0] v,
                                       input logic bs, output smcp_pkg::res_t r);
    r = '0;
    if (t == smcp_pkg::REQ_START) begin
      mode = smcp_pkg::MODE_CMD;
      cmd = '0;
      fidx = '0;
      pix_left = 0;
      org_x = 0;
      org_y = 0;
      elapsed = 0;
      target = 0;
      return 0;
    end
    if (mode == smcp_pkg::MODE_IDLE) return 0;
    if (t == smcp_pkg::REQ_TICK) begin
      if (elapsed < 65535) elapsed++;
      if (mode == smcp_pkg::MODE_WAIT) return wait_over(r);
      return 0;
    end
    if (t == smcp_pkg::REQ_KEY) begin
      if (mode == smcp_pkg::MODE_WAIT && (v & ~ign_mask) != 8'h00) begin
        mode = smcp_pkg::MODE_IDLE;
        r = mk(smcp_pkg::KIND_ABORT, 0, 0, 0, 0, int'(v));
        return 1;
      end
      return 0;
    end
    case (mode)
      smcp_pkg::MODE_CMD: return command_start(v, r);
      smcp_pkg::MODE_FIELDS: return field_in(v, r);
      smcp_pkg::MODE_PIXELS: begin
        pix_left--;
        if (pix_left == 0) mode = smcp_pkg::MODE_CMD;
        r = mk(smcp_pkg::KIND_PIXEL, 0, 0, 0, 0, int'(v));
        return 1;
      end
      smcp_pkg::MODE_SKIP: begin
        if (bs) begin
          mode = smcp_pkg::MODE_CMD;
          return command_start(v, r);
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    smcp_pkg::res_t r, e;
    if (!rst_n) begin
      fail_count = 0;
      scr_w = 10'd160;
      scr_h = 10'd128;
      ign_mask = 8'd1;
      mode = smcp_pkg::MODE_IDLE;
      cmd = '0;
      fidx = '0;
      for (int i = 0; i < 5; i++) fst[i] = '0;
      pix_left = 0;
      org_x = 0;
      org_y = 0;
      elapsed = 0;
      target = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smcp_pkg::CFG_WIDTH: scr_w = cfg_data;
          smcp_pkg::CFG_HEIGHT: scr_h = cfg_data;
          smcp_pkg::CFG_MASK: ign_mask = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        r = {out_kind, out_coord_a, out_coord_b, out_coord_c, out_coord_d, out_payload};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %p", r);
        end else begin
          e = expected_results.pop_front();
          if (r.kind !== e.kind || r.coord_a !== e.coord_a || r.coord_b !== e.coord_b ||
              r.coord_c !== e.coord_c || r.coord_d !== e.coord_d ||
              r.payload !== e.payload) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: exp %p got %p", e, r);
          end
        end
      end
      if (in_push && !in_full) begin
        if (parse_request(in_req_type, in_data_byte, in_block_start, r))
          expected_results.push_back(r);
      end
    end
  end

endmodule

>>> tb/sv/sprite_movie_command_parser_top_tb.sv
// Testbench top for the sprite movie command parser: stimulus and verdict.
`timescale 1ns / 1ps

module sprite_movie_command_parser_top_tb;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [1:0]         in_req_type;
  logic [7:0]         in_data_byte;
  logic               in_block_start;
  logic               out_empty;
  logic               out_pop;
  logic [2:0]         out_kind;
  logic signed [10:0] out_coord_a, out_coord_b, out_coord_c, out_coord_d;
  logic [15:0]        out_payload;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [9:0]         cfg_data;
  int                 fail_count;
  int                 pending;

  int n_sent;      // requests accepted so far
  int burst_left;  // requests left in the current sender burst
  int cyc = 0;

  sprite_movie_command_parser_top dut (.*);

  sprite_movie_command_parser_checker chk (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Safety net: well above the slowest legal run (stalls, long waits, hold-off).
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // Receiver: pop pattern is re-drawn at random from the cycle counter (no stall, light, heavy, half).
  // Once, well into the random part, it holds off for a long stretch so the
  // result queue and then the request queue fill and in_full is asserted.
  initial begin
    int rx_mode;
    int hold;
    rx_mode = 0;
    hold = 0;
    out_pop = 1'b0;
    @(posedge clk);
    while (1) begin
      if (cyc == 3000) hold = 400;
      if (cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          2: out_pop <= ($urandom_range(0, 3) == 0);
          default: out_pop <= 1'($urandom_range(0, 1));
        endcase
      end
      @(posedge clk);
    end
  end

  // One request through the input queue. Bursts of random length with random
  // gaps; push stays high across a burst so it is never lowered and raised in
  // one step.
  task automatic send_req(input logic [1:0] t, input logic [7:0] v, input logic bs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_req_type <= t;
    in_data_byte <= v;
    in_block_start <= bs;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_byte(input logic [7:0] v);
    send_req(smcp_pkg::REQ_BYTE, v, ($urandom_range(0, 9) == 0));
  endtask

  // Let the block drain before touching the registers: all results in, then
  // time for requests that produce none to pass through.
  task automatic drain();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [9:0] w, input logic [9:0] h, input logic [7:0] m);
    logic [9:0] vals[3];
    vals[0] = w;
    vals[1] = h;
    vals[2] = {2'b00, m};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random well-formed command with random content; a share of noise,
  // unknown commands and broken sequences.
  task automatic send_command();
    int sel, w, h, t, n;
    logic [7:0] b;
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1, 2, 3: begin
        // pixel window; mostly tiny, rarely large
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        send_byte(smcp_pkg::CH_P);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(w[7:0]);
        send_byte(h[7:0]);
        for (int i = 0; i < w * h * 2; i++) send_byte(8'($urandom_range(0, 255)));
      end
      4, 5, 6: begin
        send_byte(smcp_pkg::CH_F);
        repeat (6) send_byte(8'($urandom_range(0, 255)));
      end
      7, 8, 9: begin
        // wait; ticks until it must be over, maybe a key or dropped byte inside
        t = $urandom_range(0, 12);
        if ($urandom_range(0, 1)) begin
          send_byte(smcp_pkg::CH_WB);
          send_byte(t[7:0]);
        end else begin
          if ($urandom_range(0, 19) == 0) t = $urandom_range(256, 300);
          send_byte(smcp_pkg::CH_WS);
          send_byte(t[15:8]);
          send_byte(t[7:0]);
        end
        for (int i = 0; i <= t; i++) begin
          if ($urandom_range(0, 9) == 0)
            send_req(smcp_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
          if ($urandom_range(0, 19) == 0) begin
            send_req(smcp_pkg::REQ_KEY, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
              send_req(smcp_pkg::REQ_START, 8'($urandom_range(0, 255)), 1'b0);
          end
          send_req(smcp_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
      10, 11, 12: begin
        // skip, plain or after a seek; skipped bytes then a block start
        b = $urandom_range(0, 2) == 0 ? smcp_pkg::CH_N :
            ($urandom_range(0, 1) ? smcp_pkg::CH_SB : smcp_pkg::CH_SS);
        send_byte(b);
        if (b == smcp_pkg::CH_SB) send_byte(8'($urandom_range(0, 255)));
        if (b == smcp_pkg::CH_SS) begin
          send_byte(8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end
        n = $urandom_range(0, 5);
        repeat (n) send_req(smcp_pkg::REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        send_req(smcp_pkg::REQ_BYTE, smcp_pkg::CH_F, 1'b1);
        repeat (6) send_byte(8'($urandom_range(0, 255)));
      end
      13, 14: begin
        send_byte(smcp_pkg::CH_A);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
      15: begin
        // end of movie, ignored traffic, restart
        send_byte(smcp_pkg::CH_Z);
        repeat ($urandom_range(0, 3)) send_req(2'($urandom_range(0, 2)),
                                                8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)));
        send_req(smcp_pkg::REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      16: send_byte(8'($urandom_range(0, 255)));
      17: send_req(smcp_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      18: send_req(smcp_pkg::REQ_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: send_req(smcp_pkg::REQ_START, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endcase
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_req_type = smcp_pkg::REQ_BYTE;
    in_data_byte = 8'h00;
    in_block_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = smcp_pkg::CFG_WIDTH;
    cfg_data = 10'd0;
    n_sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values.
    send_req(smcp_pkg::REQ_BYTE, smcp_pkg::CH_Z, 1'b1);  // ignored before start
    send_req(smcp_pkg::REQ_START, 8'h00, 1'b0);
    send_byte(smcp_pkg::CH_A);                // origin from extreme sizes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(smcp_pkg::CH_P);                // empty window, no output
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(smcp_pkg::CH_F);                // fill at field extremes
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);                         // unknown command
    send_byte(smcp_pkg::CH_WB);               // zero wait: done at once
    send_byte(8'h00);
    send_byte(smcp_pkg::CH_WB);
    send_byte(8'h05);
    send_req(smcp_pkg::REQ_KEY, 8'h01, 1'b0);    // masked key, wait goes on
    send_req(smcp_pkg::REQ_BYTE, 8'h50, 1'b1);   // dropped while waiting
    send_req(smcp_pkg::REQ_KEY, 8'h80, 1'b0);    // aborts
    send_req(smcp_pkg::REQ_START, 8'hFF, 1'b1);

    // Random part in phases with different register settings.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_regs(10'd1, 10'd1, 8'h00);
        1: write_regs(10'd1023, 10'd1023, 8'hFF);
        2: write_regs(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                      8'($urandom_range(0, 255)));
        default: write_regs(10'd160, 10'd128, 8'h01);
      endcase
      send_req(smcp_pkg::REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      while (n_sent < 26 + (ph + 1) * 340) send_command();
    end

    in_push <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
